/* hdl/f12ss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f12ss_pkg
// Shared types and constants for the FAT12 sector sequencer.
// ----------------------------------------------------------------------------
package f12ss_pkg;

    // Field widths
    localparam int ADDR_W    = 24;
    localparam int CLUSTER_W = 12;
    localparam int SIC_W     = 7;
    localparam int SPC_W     = 8;
    localparam int TADDR_W   = 13;
    localparam int CFG_IDX_W = 2;

    // Table size default
    localparam int FAT_BYTES_DEFAULT = 8192;

    // Cluster entries at or above this value mark the end of a chain
    localparam logic [CLUSTER_W-1:0] END_MARK = 12'hFF8;

    // Largest usable sectors-per-cluster value
    localparam logic [SPC_W-1:0] SPC_MAX = 8'd128;

    // Register reset values
    localparam logic [ADDR_W-1:0] DATA_START_RESET = 24'd33;
    localparam logic [SPC_W-1:0]  SPC_RESET        = 8'd1;
    localparam logic [ADDR_W-1:0] ROOT_START_RESET = 24'd19;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DATA_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPC        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROOT_START = 2'd2;

    // Commands
    typedef enum logic [1:0] {
        CMD_LOAD      = 2'd0,
        CMD_OPEN_FILE = 2'd1,
        CMD_OPEN_ROOT = 2'd2,
        CMD_NEXT      = 2'd3
    } cmd_t;

endpackage

/* hdl/f12ss_fat_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f12ss_fat_ram
// Single-port allocation table memory, one byte per entry, registered read.
// ----------------------------------------------------------------------------
module f12ss_fat_ram #(
    parameter int DEPTH = 8192,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* hdl/f12ss_walker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f12ss_walker
// Command sequencer: configuration registers, file/root position, chain
// following through the table memory, sector arithmetic and output register.
// ----------------------------------------------------------------------------
module f12ss_walker
    import f12ss_pkg::*;
#(
    parameter int FAT_BYTES = FAT_BYTES_DEFAULT,
    localparam int AW       = $clog2(FAT_BYTES)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    // command channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           command,
    input  logic [TADDR_W-1:0]   table_address,
    input  logic [7:0]           table_byte,
    input  logic [CLUSTER_W-1:0] start_cluster,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [ADDR_W-1:0]    sector_address,
    output logic                 end_of_chain,
    // table memory
    output logic                 ram_we,
    output logic [AW-1:0]        ram_addr,
    output logic [7:0]           ram_wdata,
    input  logic [7:0]           ram_rdata
);

    localparam int WW = AW + 4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_LO,
        S_RD_HI,
        S_ENTRY,
        S_CHECK,
        S_MUL,
        S_ADD,
        S_OUT
    } state_t;

    state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]      data_start_reg, data_start_next;
    logic [SPC_W-1:0]       spc_reg, spc_next;
    logic [ADDR_W-1:0]      root_start_reg, root_start_next;
    logic [CLUSTER_W-1:0]   cluster_reg, cluster_next;
    logic [SIC_W-1:0]       sic_reg, sic_next;
    logic [ADDR_W-1:0]      root_sector_reg, root_sector_next;
    logic                   root_mode_reg, root_mode_next;
    logic                   ended_reg, ended_next;
    logic [7:0]             lo_byte_reg, lo_byte_next;
    logic [ADDR_W-1:0]      prod_reg, prod_next;
    logic [ADDR_W-1:0]      res_sector_reg, res_sector_next;
    logic                   res_end_reg, res_end_next;
    logic                   out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]      out_sector_reg, out_sector_next;
    logic                   out_end_reg, out_end_next;

    logic [SPC_W-1:0]       spc_eff;
    logic [SIC_W:0]         sic_inc;
    logic [TADDR_W-1:0]     entry_off;
    logic [AW-1:0]          lo_idx;
    logic [AW:0]            hi_sum;
    logic [AW-1:0]          hi_idx;
    logic [AW-1:0]          load_idx;
    logic [15:0]            entry_word;
    logic [ADDR_W-1:0]      clus_base;
    logic [ADDR_W-1:0]      root_inc;

    // Reduce a table offset modulo FAT_BYTES by four compare-subtract steps;
    // any 13-bit offset is below 16 * FAT_BYTES.
    function automatic logic [AW-1:0] fat_wrap(input logic [TADDR_W-1:0] a);
        logic [WW-1:0] v;
        v = WW'(a);
        for (int k = 3; k >= 0; k--)
        begin
            if (v >= (WW'(FAT_BYTES) << k))
            begin
                v = v - (WW'(FAT_BYTES) << k);
            end
        end
        return v[AW-1:0];
    endfunction

    assign spc_eff    = (spc_reg == '0) ? SPC_W'(1) :
                        ((spc_reg > SPC_MAX) ? SPC_MAX : spc_reg);
    assign sic_inc    = {1'b0, sic_reg} + (SIC_W+1)'(1);
    // cluster * 3 / 2
    assign entry_off  = TADDR_W'(cluster_reg) + TADDR_W'(cluster_reg >> 1);
    assign lo_idx     = fat_wrap(entry_off);
    assign hi_sum     = {1'b0, lo_idx} + (AW+1)'(1);
    assign hi_idx     = (hi_sum == (AW+1)'(FAT_BYTES)) ? '0 : hi_sum[AW-1:0];
    assign load_idx   = fat_wrap(table_address);
    assign entry_word = {ram_rdata, lo_byte_reg};
    assign clus_base  = ADDR_W'(cluster_reg) - ADDR_W'(2);
    assign root_inc   = root_sector_reg + ADDR_W'(1);

    always_comb
    begin
        state_next       = state_reg;
        data_start_next  = data_start_reg;
        spc_next         = spc_reg;
        root_start_next  = root_start_reg;
        cluster_next     = cluster_reg;
        sic_next         = sic_reg;
        root_sector_next = root_sector_reg;
        root_mode_next   = root_mode_reg;
        ended_next       = ended_reg;
        lo_byte_next     = lo_byte_reg;
        prod_next        = prod_reg;
        res_sector_next  = res_sector_reg;
        res_end_next     = res_end_reg;
        out_valid_next   = out_valid_reg;
        out_sector_next  = out_sector_reg;
        out_end_next     = out_end_reg;
        ram_we           = 1'b0;
        ram_addr         = load_idx;
        ram_wdata        = table_byte;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DATA_START: data_start_next = cfg_data;
                REG_SPC:        spc_next        = cfg_data[SPC_W-1:0];
                REG_ROOT_START: root_start_next = cfg_data;
                default:        ;
            endcase
        end

        // drop the held result once it is taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (cmd_t'(command))
                        CMD_LOAD:
                        begin
                            ram_we = 1'b1;
                        end
                        CMD_OPEN_FILE:
                        begin
                            cluster_next   = start_cluster;
                            sic_next       = '0;
                            root_mode_next = 1'b0;
                            ended_next     = 1'b0;
                            state_next     = S_MUL;
                        end
                        CMD_OPEN_ROOT:
                        begin
                            root_mode_next   = 1'b1;
                            ended_next       = 1'b0;
                            root_sector_next = root_start_reg;
                            res_sector_next  = root_start_reg;
                            res_end_next     = 1'b0;
                            state_next       = S_OUT;
                        end
                        CMD_NEXT:
                        begin
                            if (root_mode_reg)
                            begin
                                root_sector_next = root_inc;
                                res_sector_next  = root_inc;
                                res_end_next     = 1'b0;
                                state_next       = S_OUT;
                            end
                            else if (ended_reg)
                            begin
                                res_sector_next = '0;
                                res_end_next    = 1'b1;
                                state_next      = S_OUT;
                            end
                            else if (sic_inc >= (SIC_W+1)'(spc_eff))
                            begin
                                // cluster used up: follow the chain
                                sic_next   = '0;
                                state_next = S_RD_LO;
                            end
                            else
                            begin
                                sic_next   = sic_inc[SIC_W-1:0];
                                state_next = S_CHECK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD_LO:
            begin
                ram_addr   = lo_idx;
                state_next = S_RD_HI;
            end
            S_RD_HI:
            begin
                lo_byte_next = ram_rdata;
                ram_addr     = hi_idx;
                state_next   = S_ENTRY;
            end
            S_ENTRY:
            begin
                cluster_next = cluster_reg[0] ? entry_word[15:4] : entry_word[11:0];
                state_next   = S_CHECK;
            end
            S_CHECK:
            begin
                if (cluster_reg >= END_MARK)
                begin
                    ended_next      = 1'b1;
                    res_sector_next = '0;
                    res_end_next    = 1'b1;
                    state_next      = S_OUT;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = clus_base * ADDR_W'(spc_reg);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                res_sector_next = data_start_reg + prod_reg + ADDR_W'(sic_reg);
                res_end_next    = 1'b0;
                state_next      = S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_sector_next = res_sector_reg;
                    out_end_next    = res_end_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            data_start_reg  <= DATA_START_RESET;
            spc_reg         <= SPC_RESET;
            root_start_reg  <= ROOT_START_RESET;
            cluster_reg     <= '0;
            sic_reg         <= '0;
            root_sector_reg <= '0;
            root_mode_reg   <= 1'b0;
            ended_reg       <= 1'b0;
            lo_byte_reg     <= '0;
            prod_reg        <= '0;
            res_sector_reg  <= '0;
            res_end_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_sector_reg  <= '0;
            out_end_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            data_start_reg  <= data_start_next;
            spc_reg         <= spc_next;
            root_start_reg  <= root_start_next;
            cluster_reg     <= cluster_next;
            sic_reg         <= sic_next;
            root_sector_reg <= root_sector_next;
            root_mode_reg   <= root_mode_next;
            ended_reg       <= ended_next;
            lo_byte_reg     <= lo_byte_next;
            prod_reg        <= prod_next;
            res_sector_reg  <= res_sector_next;
            res_end_reg     <= res_end_next;
            out_valid_reg   <= out_valid_next;
            out_sector_reg  <= out_sector_next;
            out_end_reg     <= out_end_next;
        end
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign sector_address = out_sector_reg;
    assign end_of_chain   = out_end_reg;

endmodule

/* hdl/fat12_sector_sequencer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat12_sector_sequencer_unit
// FAT12 cluster chain walker: gives the sector address of each next sector.
// ----------------------------------------------------------------------------
// One command transaction is taken at a time. A table byte load is written
// while the sequencer stays idle. Open root, next in root mode and next after
// the end of a chain go straight to the output state; open file passes one
// 24x8 multiply stage and one add stage; next within a cluster checks the
// held cluster for an end marker, and next into a new cluster first fetches
// the 12-bit table entry as two byte reads from the single-port table memory
// and checks that; an unended chain goes on through multiply and add. A
// result waiting in the output register holds the output state while it
// stays stalled. The table memory has no reset; every entry that a chain walk
// reaches must have been loaded first.
// ----------------------------------------------------------------------------
module fat12_sector_sequencer_unit
    import f12ss_pkg::*;
#(
    parameter int FAT_BYTES = FAT_BYTES_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           command,
    input  logic [TADDR_W-1:0]   table_address,
    input  logic [7:0]           table_byte,
    input  logic [CLUSTER_W-1:0] start_cluster,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [ADDR_W-1:0]    sector_address,
    output logic                 end_of_chain
);

    localparam int AW = $clog2(FAT_BYTES);

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    f12ss_walker #(
        .FAT_BYTES(FAT_BYTES)
    ) u_walker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .table_address  (table_address),
        .table_byte     (table_byte),
        .start_cluster  (start_cluster),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .sector_address (sector_address),
        .end_of_chain   (end_of_chain),
        .ram_we         (ram_we),
        .ram_addr       (ram_addr),
        .ram_wdata      (ram_wdata),
        .ram_rdata      (ram_rdata)
    );

    f12ss_fat_ram #(
        .DEPTH(FAT_BYTES)
    ) u_fat_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

endmodule

/* hdl/f12ss_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f12ss_checker
// Port-level assertions for the FAT12 sector sequencer, bound to the top.
// ----------------------------------------------------------------------------
module f12ss_checker
    import f12ss_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic [1:0]        command,
    input logic              out_valid,
    input logic              out_stall,
    input logic [ADDR_W-1:0] sector_address,
    input logic              end_of_chain
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sector_address)
            && $stable(end_of_chain))
        else $error("stalled result changed");

    // an ended chain reports sector zero
    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_chain |-> sector_address == '0)
        else $error("end of chain with nonzero sector");

    // a table load produces no result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && command == CMD_LOAD && !out_valid |=> !out_valid)
        else $error("result after table load");

    // any other command occupies the sequencer
    a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && command != CMD_LOAD |=> in_stall)
        else $error("command accepted without going busy");

    // open root answers through the output state with a non-end result when the output is free
    a_root_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && command == CMD_OPEN_ROOT && !out_valid
            |=> ##1 out_valid && !end_of_chain)
        else $error("open root result missing");

endmodule

bind fat12_sector_sequencer_unit f12ss_checker u_f12ss_checker (.*);
